// ===== design/pixel_format_convert_macros.svh =====
// Assertion macros shared by the pixel format converter.
// No dependencies; included by the files that carry assertions.
`ifndef PIXEL_FORMAT_CONVERT_MACROS_SVH
`define PIXEL_FORMAT_CONVERT_MACROS_SVH
`ifndef SYNTHESIS
`define PFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pixel format converter check failed");
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pixel format converter check failed");
`else
`define PFC_ASSERT_NOW(label, clk, rst, ante, cons)
`define PFC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/pfc_pkg.sv =====
// Package of the pixel format converter: widths, register indexes,
// reset values, channel format type and field helpers. No dependencies.
package pfc_pkg;

  localparam int PIX_W       = 32;
  localparam int CHAN_W      = 8;
  localparam int SHIFT_W     = 5;
  localparam int NUM_CHAN    = 4;
  localparam int BPP_W       = 6;
  localparam int MAX_REG_W   = NUM_CHAN * CHAN_W;
  localparam int SHIFT_REG_W = NUM_CHAN * SHIFT_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Remainder steps done in each divider stage; must divide CHAN_W.
  localparam int DIV_STEPS_PER_STAGE = 2;

  localparam int CH_BLUE  = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_RED   = 2;
  localparam int CH_ALPHA = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_BPP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_MAX   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_SHIFT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_BPP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DST_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DST_SHIFT = 3'd5;

  localparam logic [BPP_W-1:0]       RESET_BPP   = 6'd32;
  localparam logic [MAX_REG_W-1:0]   RESET_MAX   = 32'h00FF_FFFF;
  localparam logic [SHIFT_REG_W-1:0] RESET_SHIFT = 20'hC4100;

  typedef struct packed {
    logic [CHAN_W-1:0]  smax;
    logic [CHAN_W-1:0]  dmax;
    logic [SHIFT_W-1:0] sshift;
  } chan_fmt_t;

  function automatic logic [CHAN_W-1:0] chan_max(input logic [MAX_REG_W-1:0] word,
                                                 input int unsigned ch);
    return word[ch*CHAN_W +: CHAN_W];
  endfunction

  function automatic logic [SHIFT_W-1:0] chan_shift(input logic [SHIFT_REG_W-1:0] word,
                                                    input int unsigned ch);
    return word[ch*SHIFT_W +: SHIFT_W];
  endfunction

endpackage

// ===== design/pfc_stream_if.sv =====
// Valid/ready stream interfaces for source and destination pixels.
// Depends on pfc_pkg for the pixel width.
interface pfc_src_stream_if;
  logic                    valid;
  logic                    ready;
  logic [pfc_pkg::PIX_W-1:0] src_pixel;
  modport source (output valid, output src_pixel, input ready);
  modport sink (input valid, input src_pixel, output ready);
endinterface

interface pfc_dst_stream_if;
  logic                    valid;
  logic                    ready;
  logic [pfc_pkg::PIX_W-1:0] dst_pixel;
  modport source (output valid, output dst_pixel, input ready);
  modport sink (input valid, input dst_pixel, output ready);
endinterface

// ===== design/pfc_chan_lane.sv =====
// One colour channel lane: extract and multiply, then a pipelined
// restoring divider by the source maximum. Depends on pfc_pkg.
module pfc_chan_lane #(
  parameter int DIV_STEPS = pfc_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic                                  clk,
  input  logic [pfc_pkg::CHAN_W/DIV_STEPS:0]    en,
  input  logic [pfc_pkg::PIX_W-1:0]             pixel,
  input  pfc_pkg::chan_fmt_t                    fmt,
  output logic [pfc_pkg::CHAN_W-1:0]            quot
);

  localparam int W          = pfc_pkg::CHAN_W;
  localparam int DIV_STAGES = W / DIV_STEPS;

  // Working word: upper half is the partial remainder, lower half holds the
  // dividend bits still to come and, from the bottom, the quotient bits.
  logic [2*W-1:0] work [DIV_STAGES+1];
  logic [W-1:0]   value;

  function automatic logic [2*W-1:0] div_step(input logic [2*W-1:0] w,
                                              input logic [W-1:0] d);
    logic [W:0] t;
    logic [W:0] diff;
    t    = {w[2*W-1:W], w[W-1]};
    diff = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {diff[W-1:0], w[W-2:0], 1'b1};
    end else begin
      return {t[W-1:0], w[W-2:0], 1'b0};
    end
  endfunction

  assign value = W'(pixel >> fmt.sshift) & fmt.smax;

  // The extracted value never exceeds the divisor, so the product's upper
  // half is already a valid remainder and only W quotient bits remain.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      work[0] <= (2*W)'(value) * (2*W)'(fmt.dmax);
    end
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [2*W-1:0] acc;
    always_comb begin
      acc = work[j-1];
      for (int s = 0; s < DIV_STEPS; s++) begin
        acc = div_step(acc, fmt.smax);
      end
    end
    always_ff @(posedge clk) begin
      if (en[j]) begin
        work[j] <= acc;
      end
    end
  end

  assign quot = work[DIV_STAGES][W-1:0];

endmodule

// ===== design/pixel_format_convert.sv =====
// Pixel format converter, top level. Takes one packed pixel per transfer
// and gives it repacked in the destination format. Depends on pfc_pkg,
// pfc_stream_if, pfc_chan_lane and pixel_format_convert_macros.svh.
//
// One pixel is accepted every clock unless back-pressure holds the first
// stage, and results leave in order, one per source pixel. One stage
// extracts and multiplies each channel, the restoring divider by the source
// maximum spends DIV_STEPS_PER_STAGE remainder steps in each following
// stage, and a last stage selects between the pass-through, alpha clear,
// alpha set and repacked results into the output register. Each stage holds
// only while the stage after it is full and stalled, so bubbles close up
// under back-pressure. The formats must be written only while no pixel is
// in flight.
`include "pixel_format_convert_macros.svh"

module pixel_format_convert #(
  parameter int DIV_STEPS = pfc_pkg::DIV_STEPS_PER_STAGE
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [pfc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfc_pkg::CFG_DATA_W-1:0]    cfg_data,
  pfc_src_stream_if.sink                    src,
  pfc_dst_stream_if.source                  dst
);

  localparam int DIV_STAGES = pfc_pkg::CHAN_W / DIV_STEPS;
  localparam int NS         = DIV_STAGES + 2;

  logic [pfc_pkg::BPP_W-1:0]       src_bpp;
  logic [pfc_pkg::MAX_REG_W-1:0]   src_max;
  logic [pfc_pkg::SHIFT_REG_W-1:0] src_shift;
  logic [pfc_pkg::BPP_W-1:0]       dst_bpp;
  logic [pfc_pkg::MAX_REG_W-1:0]   dst_max;
  logic [pfc_pkg::SHIFT_REG_W-1:0] dst_shift;

  logic [NS-1:0]              vld;
  logic [NS-1:0]              en;
  logic [pfc_pkg::PIX_W-1:0]  pix [DIV_STAGES+1];
  logic [pfc_pkg::PIX_W-1:0]  result;
  logic [pfc_pkg::PIX_W-1:0]  dst_pixel_reg;
  logic [pfc_pkg::CHAN_W-1:0] quot [pfc_pkg::NUM_CHAN];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      src_bpp   <= pfc_pkg::RESET_BPP;
      src_max   <= pfc_pkg::RESET_MAX;
      src_shift <= pfc_pkg::RESET_SHIFT;
      dst_bpp   <= pfc_pkg::RESET_BPP;
      dst_max   <= pfc_pkg::RESET_MAX;
      dst_shift <= pfc_pkg::RESET_SHIFT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pfc_pkg::REG_SRC_BPP:   src_bpp   <= cfg_data[pfc_pkg::BPP_W-1:0];
        pfc_pkg::REG_SRC_MAX:   src_max   <= cfg_data[pfc_pkg::MAX_REG_W-1:0];
        pfc_pkg::REG_SRC_SHIFT: src_shift <= cfg_data[pfc_pkg::SHIFT_REG_W-1:0];
        pfc_pkg::REG_DST_BPP:   dst_bpp   <= cfg_data[pfc_pkg::BPP_W-1:0];
        pfc_pkg::REG_DST_MAX:   dst_max   <= cfg_data[pfc_pkg::MAX_REG_W-1:0];
        pfc_pkg::REG_DST_SHIFT: dst_shift <= cfg_data[pfc_pkg::SHIFT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or its contents move on this cycle.
  always_comb begin
    en[NS-1] = !vld[NS-1] || dst.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign src.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= src.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pix[0] <= src.src_pixel;
    end
    for (int k = 1; k <= DIV_STAGES; k++) begin
      if (en[k]) begin
        pix[k] <= pix[k-1];
      end
    end
  end

  for (genvar c = 0; c < pfc_pkg::NUM_CHAN; c++) begin : g_lane
    pfc_pkg::chan_fmt_t fmt;
    assign fmt.smax   = pfc_pkg::chan_max(src_max, c);
    assign fmt.dmax   = pfc_pkg::chan_max(dst_max, c);
    assign fmt.sshift = pfc_pkg::chan_shift(src_shift, c);

    pfc_chan_lane #(
      .DIV_STEPS (DIV_STEPS)
    ) u_lane (
      .clk   (clk),
      .en    (en[DIV_STAGES:0]),
      .pixel (src.src_pixel),
      .fmt   (fmt),
      .quot  (quot[c])
    );
  end

  // Final selection. The user must keep the configuration steady while pixels
  // are in flight (the block does not enforce it), so it is read directly here.
  always_comb begin
    logic                        alike;
    logic [pfc_pkg::CHAN_W-1:0]  samax;
    logic [pfc_pkg::CHAN_W-1:0]  damax;
    logic [pfc_pkg::SHIFT_W-1:0] sash;
    logic [pfc_pkg::SHIFT_W-1:0] dash;
    logic [pfc_pkg::CHAN_W-1:0]  chv;
    logic [pfc_pkg::PIX_W-1:0]   packed_px;
    alike = (src_bpp == dst_bpp)
         && (src_max[3*pfc_pkg::CHAN_W-1:0] == dst_max[3*pfc_pkg::CHAN_W-1:0])
         && (src_shift[3*pfc_pkg::SHIFT_W-1:0] == dst_shift[3*pfc_pkg::SHIFT_W-1:0]);
    samax = pfc_pkg::chan_max(src_max, pfc_pkg::CH_ALPHA);
    damax = pfc_pkg::chan_max(dst_max, pfc_pkg::CH_ALPHA);
    sash  = pfc_pkg::chan_shift(src_shift, pfc_pkg::CH_ALPHA);
    dash  = pfc_pkg::chan_shift(dst_shift, pfc_pkg::CH_ALPHA);
    packed_px = '0;
    for (int c = 0; c < pfc_pkg::NUM_CHAN; c++) begin
      // An empty source channel always yields zero, whatever the divider gave.
      if (pfc_pkg::chan_max(src_max, c) == '0) begin
        chv = '0;
      end else begin
        chv = quot[c];
      end
      packed_px = packed_px
                | (pfc_pkg::PIX_W'(chv) << pfc_pkg::chan_shift(dst_shift, c));
    end
    if (alike && samax == damax && sash == dash) begin
      result = pix[DIV_STAGES];
    end else if (alike && damax == '0 && samax != '0) begin
      result = pix[DIV_STAGES] & ~(pfc_pkg::PIX_W'(samax) << sash);
    end else if (alike && damax != '0 && samax == '0) begin
      result = pix[DIV_STAGES] | (pfc_pkg::PIX_W'(damax) << dash);
    end else begin
      result = packed_px;
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      dst_pixel_reg <= result;
    end
  end

  assign dst.valid     = vld[NS-1];
  assign dst.dst_pixel = dst_pixel_reg;

  // An accepted pixel always occupies the first stage next cycle.
  `PFC_ASSERT_NEXT(a_accept_fills_first, clk, rst, src.valid && src.ready, vld[0])
  // A full first stage that cannot move keeps its pixel.
  `PFC_ASSERT_NEXT(a_first_holds, clk, rst, vld[0] && !en[0], vld[0])
  // Occupancy rises by one on an input transfer without an output transfer.
  `PFC_ASSERT_NEXT(a_count_up, clk, rst, src.valid && src.ready && !(dst.valid && dst.ready), $countones(vld) == $past($countones(vld)) + 1)
  // Occupancy falls by one on an output transfer without an input transfer.
  `PFC_ASSERT_NEXT(a_count_down, clk, rst, !(src.valid && src.ready) && dst.valid && dst.ready, $countones(vld) + 1 == $past($countones(vld)))

endmodule
